// ===== rtl/bam_pkg.sv =====
package bam_pkg;

    // Fixed widths of the stream fields and the configuration registers.
    localparam int PIX_W      = 16;
    localparam int NUM_CH     = 4;
    localparam int BS_REG_W   = 7;
    localparam int IA_W       = 25;
    localparam int DOT_W      = 21;
    localparam int IW_REG_W   = 11;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 25;

    // The inverse area is Q1.24 and is split in two for the multiply.
    localparam int AVG_FRAC   = 24;
    localparam int IA_LO_W    = 13;
    localparam int IA_HI_W    = IA_W - IA_LO_W;

    // The circle test scales the squared distance into Q.8.
    localparam int DIST_FRAC  = 8;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_cfg_idx REG_BLOCK_SIZE   = 2'd0;
    localparam t_cfg_idx REG_INVERSE_AREA = 2'd1;
    localparam t_cfg_idx REG_DOT_DIAM_SQ  = 2'd2;
    localparam t_cfg_idx REG_IMAGE_WIDTH  = 2'd3;

endpackage

// ===== rtl/bam_ram.sv =====
module bam_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Read returns the old contents when the same entry is written at once.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/block_average_dot_mosaic.sv =====
// Channel        Direction  Handshake                  Payload
// input pixel    in         i_in_valid / o_in_stall    i_red_in .. i_alpha_in, i_flush
// output pixel   out        o_out_valid / i_out_stall  o_red_out .. o_alpha_out, o_row_end
// configuration  in         i_cfg_we                   i_cfg_index, i_cfg_data
//
// One request is taken every clock cycle while the output register is free or being
// emptied; the sum store's single read-modify-write per pixel sets that rate.
// An accepted request passes through stages 1, 2, 3 and 4 into the output register.
// Reset (synchronous, active low) clears the counters, the pipeline valid bits and the
// output valid bit, and loads the register defaults; the two stores are not cleared.
// A stall on a full output register freezes the whole pipeline and raises o_in_stall
// in the same cycle.
module block_average_dot_mosaic #(
    parameter int MAX_WIDTH    = 1024,
    parameter int MAX_BLOCK    = 64,
    parameter int CHANNEL_BITS = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic [bam_pkg::PIX_W-1:0]    i_red_in,
    input  logic [bam_pkg::PIX_W-1:0]    i_green_in,
    input  logic [bam_pkg::PIX_W-1:0]    i_blue_in,
    input  logic [bam_pkg::PIX_W-1:0]    i_alpha_in,
    input  logic                         i_flush,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [bam_pkg::PIX_W-1:0]    o_red_out,
    output logic [bam_pkg::PIX_W-1:0]    o_green_out,
    output logic [bam_pkg::PIX_W-1:0]    o_blue_out,
    output logic [bam_pkg::PIX_W-1:0]    o_alpha_out,
    output logic                         o_row_end,
    input  logic                         i_cfg_we,
    input  bam_pkg::t_cfg_idx            i_cfg_index,
    input  logic [bam_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    // Address, counter and arithmetic widths all follow from the parameters.
    localparam int AW   = $clog2(MAX_WIDTH);
    localparam int WW   = $clog2(MAX_WIDTH + 1);
    localparam int BW   = $clog2(MAX_BLOCK);
    localparam int BSW  = $clog2(MAX_BLOCK + 1);
    localparam int CW   = CHANNEL_BITS;
    localparam int SW   = CW + 2 * BW;
    localparam int DXW  = BSW + 2;
    localparam int SQW  = 2 * DXW + 1;
    localparam int DSW  = SQW + bam_pkg::DIST_FRAC;
    localparam int CMPW = (DSW > bam_pkg::DOT_W) ? DSW : bam_pkg::DOT_W;
    localparam int PLW  = SW + bam_pkg::IA_LO_W;
    localparam int PHW  = SW + bam_pkg::IA_HI_W;
    localparam int PW   = SW + bam_pkg::IA_W + 1;
    localparam int NCH  = bam_pkg::NUM_CH;
    localparam logic [CW-1:0] CH_MAX = {CW{1'b1}};

    // ------------------------------------------------------------------
    // Configuration registers.
    // ------------------------------------------------------------------
    logic [bam_pkg::BS_REG_W-1:0] r_cfg_bs;
    logic [bam_pkg::IA_W-1:0]     r_cfg_ia;
    logic [bam_pkg::DOT_W-1:0]    r_cfg_dot;
    logic [bam_pkg::IW_REG_W-1:0] r_cfg_w;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_bs  <= bam_pkg::BS_REG_W'(16);
            r_cfg_ia  <= bam_pkg::IA_W'(65536);
            r_cfg_dot <= bam_pkg::DOT_W'(65536);
            r_cfg_w   <= bam_pkg::IW_REG_W'(1024);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                bam_pkg::REG_BLOCK_SIZE: begin
                    r_cfg_bs <= i_cfg_data[bam_pkg::BS_REG_W-1:0];
                end
                bam_pkg::REG_INVERSE_AREA: begin
                    r_cfg_ia <= i_cfg_data[bam_pkg::IA_W-1:0];
                end
                bam_pkg::REG_DOT_DIAM_SQ: begin
                    r_cfg_dot <= i_cfg_data[bam_pkg::DOT_W-1:0];
                end
                bam_pkg::REG_IMAGE_WIDTH: begin
                    r_cfg_w <= i_cfg_data[bam_pkg::IW_REG_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // The block size and the width are clamped into the range that the
    // stores and counters were sized for; zero behaves as one.
    logic [BSW-1:0] bs_eff;
    logic [WW-1:0]  w_eff;

    always_comb begin
        if (r_cfg_bs == '0) begin
            bs_eff = BSW'(1);
        end else if (32'(r_cfg_bs) > 32'(MAX_BLOCK)) begin
            bs_eff = BSW'(MAX_BLOCK);
        end else begin
            bs_eff = BSW'(r_cfg_bs);
        end
        if (r_cfg_w == '0) begin
            w_eff = WW'(1);
        end else if (32'(r_cfg_w) > 32'(MAX_WIDTH)) begin
            w_eff = WW'(MAX_WIDTH);
        end else begin
            w_eff = WW'(r_cfg_w);
        end
    end

    // ------------------------------------------------------------------
    // Flow control. The pipeline moves as a whole whenever the output
    // register is empty or its content is taken in this cycle.
    // ------------------------------------------------------------------
    logic r_out_valid;
    logic adv;
    logic accept;

    assign adv        = !r_out_valid || !i_out_stall;
    assign accept     = i_in_valid && adv;
    assign o_in_stall = !adv;

    // ------------------------------------------------------------------
    // Stage 0: position counters. Every decision about the pixel's place
    // in the block grid is made here, from the counters as they stand
    // when the request is accepted.
    // ------------------------------------------------------------------
    logic [AW-1:0] r_col_pos;
    logic [BW-1:0] r_col_in_blk;
    logic [BW-1:0] r_row_in_blk;
    logic [AW-1:0] r_blk_col;
    logic          r_avg_ready;

    logic last_col_blk;
    logic last_row_blk;
    logic row_last;
    logic first_pix;
    logic wr_avg0;
    logic signed [DXW-1:0] dx0;
    logic signed [DXW-1:0] dy0;

    assign last_col_blk = (BSW'(r_col_in_blk) + BSW'(1)) >= bs_eff
                          || r_col_in_blk == {BW{1'b1}};
    assign last_row_blk = (BSW'(r_row_in_blk) + BSW'(1)) >= bs_eff
                          || r_row_in_blk == {BW{1'b1}};
    assign row_last     = ((WW + 1)'(r_col_pos) + (WW + 1)'(1)) >= (WW + 1)'(w_eff);
    assign first_pix    = (r_row_in_blk == '0) && (r_col_in_blk == '0);
    assign wr_avg0      = !i_flush && last_row_blk && (last_col_blk || row_last);
    assign dx0 = $signed(DXW'({r_col_in_blk, 1'b0})) - $signed(DXW'(bs_eff));
    assign dy0 = $signed(DXW'({r_row_in_blk, 1'b0})) - $signed(DXW'(bs_eff));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col_pos    <= '0;
            r_col_in_blk <= '0;
            r_row_in_blk <= '0;
            r_blk_col    <= '0;
            r_avg_ready  <= 1'b0;
        end else if (accept) begin
            if (row_last) begin
                r_col_pos    <= '0;
                r_col_in_blk <= '0;
                r_blk_col    <= '0;
                if (last_row_blk) begin
                    r_row_in_blk <= '0;
                    // A block row closed by a flush leaves nothing to emit.
                    r_avg_ready  <= !i_flush;
                end else begin
                    r_row_in_blk <= r_row_in_blk + BW'(1);
                end
            end else begin
                r_col_pos <= r_col_pos + AW'(1);
                if (last_col_blk) begin
                    r_col_in_blk <= '0;
                    r_blk_col    <= r_blk_col + AW'(1);
                end else begin
                    r_col_in_blk <= r_col_in_blk + BW'(1);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Sum store: one entry of four running sums per block column. It is
    // read as the request is accepted and written back from stage 1.
    // When the entry written back is the one read at the same edge, the
    // written data is kept aside and used in place of the stale read.
    // ------------------------------------------------------------------
    logic          sum_we;
    logic [AW-1:0] sum_waddr;
    logic [NCH*SW-1:0] sum_wdata;
    logic [NCH*SW-1:0] sum_rdata;
    logic          r_fwd_hit;
    logic [NCH*SW-1:0] r_fwd_data;

    bam_ram #(
        .WIDTH (NCH * SW),
        .DEPTH (MAX_WIDTH)
    ) u_sum_ram (
        .i_clk   (i_clk),
        .i_we    (sum_we),
        .i_waddr (sum_waddr),
        .i_wdata (sum_wdata),
        .i_re    (accept),
        .i_raddr (r_blk_col),
        .o_rdata (sum_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd_hit <= 1'b0;
        end else if (accept) begin
            r_fwd_hit <= sum_we && (sum_waddr == r_blk_col);
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_fwd_data <= sum_wdata;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: accumulate and write the sums back.
    // ------------------------------------------------------------------
    logic          r_s1_valid;
    logic          r1_flush;
    logic          r1_first;
    logic          r1_wr_avg;
    logic          r1_emit;
    logic          r1_row_end;
    logic [AW-1:0] r1_bc;
    logic signed [DXW-1:0] r1_dx;
    logic signed [DXW-1:0] r1_dy;
    logic [CW-1:0] r1_pix [NCH];

    logic [NCH*SW-1:0] old_sums;
    logic [SQW-1:0]    sq1;

    assign old_sums  = r_fwd_hit ? r_fwd_data : sum_rdata;
    assign sum_we    = adv && r_s1_valid;
    assign sum_waddr = r1_bc;
    assign sq1       = $unsigned(SQW'(r1_dx) * SQW'(r1_dx))
                       + $unsigned(SQW'(r1_dy) * SQW'(r1_dy));

    always_comb begin
        logic [SW-1:0] base;
        for (int c = 0; c < NCH; c++) begin
            base = r1_first ? '0 : old_sums[c*SW +: SW];
            sum_wdata[c*SW +: SW] = r1_flush ? base : base + SW'(r1_pix[c]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (adv) begin
            r_s1_valid <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r1_flush   <= i_flush;
            r1_first   <= first_pix;
            r1_wr_avg  <= wr_avg0;
            r1_emit    <= r_avg_ready;
            r1_row_end <= row_last;
            r1_bc      <= r_blk_col;
            r1_dx      <= dx0;
            r1_dy      <= dy0;
            r1_pix[0]  <= i_red_in[CW-1:0];
            r1_pix[1]  <= i_green_in[CW-1:0];
            r1_pix[2]  <= i_blue_in[CW-1:0];
            r1_pix[3]  <= i_alpha_in[CW-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: partial products of sum times inverse area, and the dot
    // test on the squared distance.
    // ------------------------------------------------------------------
    logic          r_s2_valid;
    logic          r2_wr_avg;
    logic          r2_emit;
    logic          r2_row_end;
    logic [AW-1:0] r2_bc;
    logic [SQW-1:0] r2_sq;
    logic [SW-1:0] r2_sum [NCH];

    logic [CMPW-1:0] dist2;
    logic            inside2;

    assign dist2   = CMPW'({r2_sq, {bam_pkg::DIST_FRAC{1'b0}}});
    assign inside2 = dist2 <= CMPW'(r_cfg_dot);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (adv) begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r2_wr_avg  <= r1_wr_avg;
            r2_emit    <= r1_emit;
            r2_row_end <= r1_row_end;
            r2_bc      <= r1_bc;
            r2_sq      <= sq1;
            for (int c = 0; c < NCH; c++) begin
                r2_sum[c] <= sum_wdata[c*SW +: SW];
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: combine, round and saturate; write the new average and
    // read the previous block row's average for the same column. The
    // read sees the old entry, which is the one this pixel shows.
    // ------------------------------------------------------------------
    logic          r_s3_valid;
    logic          r3_wr_avg;
    logic          r3_emit;
    logic          r3_row_end;
    logic          r3_inside;
    logic [AW-1:0] r3_bc;
    logic [PLW-1:0] r3_pl [NCH];
    logic [PHW-1:0] r3_ph [NCH];

    logic [NCH*CW-1:0] avg_wdata;
    logic [NCH*CW-1:0] avg_rdata;
    logic              avg_we;
    logic              avg_re;

    always_comb begin
        logic [PW-1:0] total;
        for (int c = 0; c < NCH; c++) begin
            total = (PW'(r3_ph[c]) << bam_pkg::IA_LO_W) + PW'(r3_pl[c])
                    + (PW'(1) << (bam_pkg::AVG_FRAC - 1));
            if (total[PW-1:bam_pkg::AVG_FRAC+CW] != '0) begin
                avg_wdata[c*CW +: CW] = CH_MAX;
            end else begin
                avg_wdata[c*CW +: CW] = total[bam_pkg::AVG_FRAC +: CW];
            end
        end
    end

    assign avg_we = adv && r_s3_valid && r3_wr_avg;
    assign avg_re = adv && r_s3_valid;

    bam_ram #(
        .WIDTH (NCH * CW),
        .DEPTH (MAX_WIDTH)
    ) u_avg_ram (
        .i_clk   (i_clk),
        .i_we    (avg_we),
        .i_waddr (r3_bc),
        .i_wdata (avg_wdata),
        .i_re    (avg_re),
        .i_raddr (r3_bc),
        .o_rdata (avg_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_valid <= 1'b0;
        end else if (adv) begin
            r_s3_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r3_wr_avg  <= r2_wr_avg;
            r3_emit    <= r2_emit;
            r3_row_end <= r2_row_end;
            r3_inside  <= inside2;
            r3_bc      <= r2_bc;
            for (int c = 0; c < NCH; c++) begin
                r3_pl[c] <= PLW'(r2_sum[c]) * PLW'(r_cfg_ia[bam_pkg::IA_LO_W-1:0]);
                r3_ph[c] <= PHW'(r2_sum[c])
                            * PHW'(r_cfg_ia[bam_pkg::IA_W-1:bam_pkg::IA_LO_W]);
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: the average arrives from the store and is masked by the
    // dot test into the output register.
    // ------------------------------------------------------------------
    logic r_s4_valid;
    logic r4_emit;
    logic r4_row_end;
    logic r4_inside;
    logic [bam_pkg::PIX_W-1:0] r_out_pix [NCH];
    logic r_out_row_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s4_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_s4_valid  <= r_s3_valid;
            r_out_valid <= r_s4_valid && r4_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r4_emit       <= r3_emit;
            r4_row_end    <= r3_row_end;
            r4_inside     <= r3_inside;
            r_out_row_end <= r4_row_end;
            for (int c = 0; c < NCH; c++) begin
                r_out_pix[c] <= r4_inside ? bam_pkg::PIX_W'(avg_rdata[c*CW +: CW])
                                          : '0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_red_out   = r_out_pix[0];
    assign o_green_out = r_out_pix[1];
    assign o_blue_out  = r_out_pix[2];
    assign o_alpha_out = r_out_pix[3];
    assign o_row_end   = r_out_row_end;

endmodule

// ===== rtl/bam_checker.sv =====
module bam_checker (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      o_in_stall,
    input logic                      o_out_valid,
    input logic                      i_out_stall,
    input logic [bam_pkg::PIX_W-1:0] o_red_out,
    input logic                      o_row_end
);

    // Results held back by the sink must stay put.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_red_out)
                                       && $stable(o_row_end))
        else $error("stalled result changed");

    // The input is only held off when a finished result is blocked.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled without a blocked result");

    // Nothing is shown straight after reset.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // A free output never holds off the input.
    a_free_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> !o_in_stall)
        else $error("input stalled with empty output");

endmodule

bind block_average_dot_mosaic bam_checker u_bam_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_red_out   (o_red_out),
    .o_row_end   (o_row_end)
);
